[hdl/masked_byte_signature_search_assert.svh]
// Assertion macros for the signature search block.
`ifndef MASKED_BYTE_SIGNATURE_SEARCH_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SEARCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signature search assertion failed");
`define MBSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("signature search assertion failed");
`else
`define MBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MBSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/mbss_pkg.sv]
`default_nettype none
package mbss_pkg;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int SIG_BYTES       = 16;
    localparam int DATA_W          = 8;
    localparam int OFFSET_W        = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MASK_W          = 16;
    localparam int LEN_W           = 5;
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_WILDCARD     = 2'd2,
        REG_LENGTH       = 2'd3
    } t_cfg_idx;

    typedef logic [DATA_W-1:0] t_byte;
endpackage
`default_nettype wire

[hdl/mbss_window.sv]
`default_nettype none
module mbss_window #(
    parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEF,
    parameter int WIN         = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire mbss_pkg::t_byte               i_data,
    input  wire logic                          i_last,
    output mbss_pkg::t_byte                    o_window [WIN],
    output logic [mbss_pkg::OFFSET_W-1:0]      o_pos
);
    mbss_pkg::t_byte                   r_window [WIN];
    logic [mbss_pkg::OFFSET_W-1:0]     r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) r_window[k] <= '0;
            r_pos <= '0;
        end else if (i_shift) begin
            if (i_last) begin
                // The buffer ends here: the next byte starts a fresh buffer.
                for (int k = 0; k < WIN; k++) r_window[k] <= '0;
                r_pos <= '0;
            end else begin
                for (int k = WIN - 1; k > 0; k--) r_window[k] <= r_window[k-1];
                r_window[0] <= i_data;
                r_pos       <= r_pos + mbss_pkg::OFFSET_W'(1);
            end
        end
    end

    assign o_window = r_window;
    assign o_pos    = r_pos;
endmodule
`default_nettype wire

[hdl/mbss_matcher.sv]
`default_nettype none
module mbss_matcher #(
    parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEF,
    parameter int WIN         = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  wire mbss_pkg::t_byte                     i_cur,
    input  wire mbss_pkg::t_byte                     i_window [WIN],
    input  wire logic [mbss_pkg::OFFSET_W-1:0]       i_pos,
    input  wire logic [8*mbss_pkg::SIG_BYTES-1:0]    i_pattern,
    input  wire logic [mbss_pkg::MASK_W-1:0]         i_mask,
    input  wire logic [LW-1:0]                       i_len,
    output logic                                     o_hit,
    output logic [mbss_pkg::OFFSET_W-1:0]            o_offset
);
    localparam int HW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    mbss_pkg::t_byte                 hist [MAX_PATTERN];
    logic [LW-1:0]                   back [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]          pos_ok;
    logic                            start_ok;

    // hist[j] is the byte j places before the current one.
    always_comb begin
        hist[0] = i_cur;
        for (int j = 1; j < MAX_PATTERN; j++) hist[j] = i_window[j-1];
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            back[i]   = i_len - LW'(i) - LW'(1);
            pos_ok[i] = 1'b1;
            if (LW'(i) < i_len && !i_mask[i]) begin
                pos_ok[i] = (hist[back[i][HW-1:0]] == i_pattern[8*i +: 8]);
            end
        end
    end

    // The whole signature must lie inside the current buffer.
    assign start_ok = ({1'b0, i_pos} + 33'd1) >= 33'(i_len);

    always_comb begin
        if (i_len == '0) begin
            o_hit    = 1'b1;
            o_offset = i_pos;
        end else begin
            o_hit    = start_ok && (&pos_ok);
            o_offset = i_pos - mbss_pkg::OFFSET_W'(i_len) + mbss_pkg::OFFSET_W'(1);
        end
    end
endmodule
`default_nettype wire

[hdl/masked_byte_signature_search.sv]
// Masked byte signature search.
// Bytes of a buffer arrive on the slave stream, one per request, with tlast on the
// final byte. Each match of the configured signature (up to MAX_PATTERN bytes, with
// a per-position wildcard mask) that ends at a byte yields one request on the master
// stream carrying the 32-bit offset at which the match begins.
// Configuration is written through the cfg channel (index 0 pattern low, 1 pattern
// high, 2 wildcard mask, 3 length) while the block is idle; the user must keep to
// this, as the block does not enforce it. o_cfg_ready is always high. Throughput is
// one byte per cycle while the receiver does not stall: a byte is taken into the input
// register, and once the result register is free or draining the window compare runs
// and the result register is loaded. The input register refills in the same cycle it
// drains, so back-to-back bytes flow without bubbles. When the receiver stalls, the
// result register holds its request and the input register holds the next byte;
// o_s_tready drops only when both are full. Reset clears the byte window, the offset
// counter, both stage valids and the configuration (length 1, everything else zero).
`default_nettype none
module masked_byte_signature_search #(
    parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [mbss_pkg::DATA_W-1:0]         i_s_tdata,  // [7:0] data_byte
    input  wire logic                                i_s_tlast,  // last_byte
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [mbss_pkg::OFFSET_W-1:0]            o_m_tdata,  // [31:0] match_offset
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mbss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mbss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    `include "masked_byte_signature_search_assert.svh"

    localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int LW  = $clog2(MAX_PATTERN + 1);

    logic [mbss_pkg::CFG_DATA_W-1:0]   r_pat_lo;
    logic [mbss_pkg::CFG_DATA_W-1:0]   r_pat_hi;
    logic [mbss_pkg::MASK_W-1:0]       r_mask;
    logic [mbss_pkg::LEN_W-1:0]        r_len;
    logic [LW-1:0]                     len_sat;

    logic                              r_in_valid;
    mbss_pkg::t_byte                   r_in_data;
    logic                              r_in_last;
    logic                              r_out_valid;
    logic [mbss_pkg::OFFSET_W-1:0]     r_out_offset;

    logic                              adv;
    logic                              hit;
    logic [mbss_pkg::OFFSET_W-1:0]     offset;
    mbss_pkg::t_byte                   window [WIN];
    logic [mbss_pkg::OFFSET_W-1:0]     pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_mask   <= '0;
            r_len    <= mbss_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            case (mbss_pkg::t_cfg_idx'(i_cfg_index))
                mbss_pkg::REG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                mbss_pkg::REG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                mbss_pkg::REG_WILDCARD:     r_mask   <= i_cfg_data[mbss_pkg::MASK_W-1:0];
                mbss_pkg::REG_LENGTH:       r_len    <= i_cfg_data[mbss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_sat = (r_len > mbss_pkg::LEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                             : r_len[LW-1:0];

    // The held byte moves on once the result register is free or draining.
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    mbss_window #(.MAX_PATTERN(MAX_PATTERN), .WIN(WIN)) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (adv),
        .i_data   (r_in_data),
        .i_last   (r_in_last),
        .o_window (window),
        .o_pos    (pos)
    );

    mbss_matcher #(.MAX_PATTERN(MAX_PATTERN), .WIN(WIN), .LW(LW)) u_matcher (
        .i_cur     (r_in_data),
        .i_window  (window),
        .i_pos     (pos),
        .i_pattern ({r_pat_hi, r_pat_lo}),
        .i_mask    (r_mask),
        .i_len     (len_sat),
        .o_hit     (hit),
        .o_offset  (offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= adv && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_offset <= offset;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_offset;

    `MBSS_ASSERT_NEXT(a_zero_len_reports, i_clk, i_rst_n, adv && (len_sat == '0), r_out_valid)
    `MBSS_ASSERT_NEXT(a_last_clears_pos, i_clk, i_rst_n, adv && r_in_last, pos == '0)
    `MBSS_ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n, adv && !r_in_last, pos == $past(pos) + 32'd1)
    `MBSS_ASSERT_NEXT(a_idle_pos_holds, i_clk, i_rst_n, !adv, $stable(pos))
endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        mbss_pkg::t_byte data;
        logic            last;
    } t_byte_item;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_valid   = 1'b0;
    logic [mbss_pkg::DATA_W-1:0]     s_data    = '0;
    logic                            s_last    = 1'b0;
    logic                            m_ready   = 1'b0;
    logic                            cfg_valid = 1'b0;
    mbss_pkg::t_cfg_idx              cfg_index = mbss_pkg::REG_PATTERN_LOW;
    logic [mbss_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                            s_ready;
    logic                            m_valid;
    logic [mbss_pkg::OFFSET_W-1:0]   m_data;
    logic                            cfg_ready;

    // Shadow of the configuration registers, starting at their reset values.
    logic [63:0]                     sig_lo    = '0;
    logic [63:0]                     sig_hi    = '0;
    logic [mbss_pkg::MASK_W-1:0]     wild_mask = '0;
    logic [mbss_pkg::LEN_W-1:0]      sig_len   = mbss_pkg::LEN_RESET;

    // Predicted search state: recent[0] is the byte that came just before the current one.
    mbss_pkg::t_byte                 recent [0:mbss_pkg::SIG_BYTES-2] = '{default: '0};
    logic [mbss_pkg::OFFSET_W-1:0]   cur_pos   = '0;

    t_byte_item                      byte_q[$];
    logic [mbss_pkg::OFFSET_W-1:0]   offset_q[$];
    t_byte_item                      next_item;
    int                              send_gap  = 0;
    int                              stall     = 0;
    int                              errors    = 0;
    int                              rand_items = 0;
    bit                              calm      = 1'b0;

    masked_byte_signature_search uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic mbss_pkg::t_byte sig_byte(input int i);
        if (i < 8)
            return sig_lo[8*i +: 8];
        return sig_hi[8*(i-8) +: 8];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_pattern();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Predicts the offset reported for one accepted byte, then advances the window.
    task automatic scan_byte(input mbss_pkg::t_byte cur, input logic last);
        int              len;
        bit              hit;
        mbss_pkg::t_byte b;
        len = (sig_len > mbss_pkg::MAX_PATTERN_DEF) ? mbss_pkg::MAX_PATTERN_DEF
                                                     : int'(sig_len);
        if (len == 0) begin
            offset_q = {offset_q, cur_pos};
        end else if (64'(cur_pos) + 64'd1 >= 64'(len)) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                b = (i == len - 1) ? cur : recent[len-2-i];
                if (!wild_mask[i] && b != sig_byte(i))
                    hit = 1'b0;
            end
            if (hit)
                offset_q = {offset_q, cur_pos - mbss_pkg::OFFSET_W'(len - 1)};
        end
        if (last) begin
            recent = '{default: '0};
            cur_pos = '0;
        end else begin
            for (int k = mbss_pkg::SIG_BYTES - 2; k > 0; k--)
                recent[k] = recent[k-1];
            recent[0] = cur;
            cur_pos = cur_pos + mbss_pkg::OFFSET_W'(1);
        end
    endtask

    task automatic add_byte(input mbss_pkg::t_byte data, input logic last);
        byte_q = {byte_q, t_byte_item'{data: data, last: last}};
    endtask

    task automatic write_reg(input mbss_pkg::t_cfg_idx idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mbss_pkg::REG_PATTERN_LOW:  sig_lo    = value;
            mbss_pkg::REG_PATTERN_HIGH: sig_hi    = value;
            mbss_pkg::REG_WILDCARD:     wild_mask = value[mbss_pkg::MASK_W-1:0];
            mbss_pkg::REG_LENGTH:       sig_len   = value[mbss_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every byte is taken and every predicted offset has come back,
    // then lets the pipeline drain.
    task automatic wait_idle(input int settle);
        while (byte_q.size() != 0 || s_valid || offset_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                scan_byte(s_data, s_last);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    next_item = byte_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= next_item.data;
                    s_last  <= next_item.last;
                    send_gap = calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (offset_q.size() == 0) begin
                    $display("%0t: unexpected match_offset, expected none, got %h",
                             $time, m_data);
                    errors = errors + 1;
                end else if (offset_q[0] !== m_data) begin
                    $display("%0t: match_offset mismatch, expected %h, got %h",
                             $time, offset_q[0], m_data);
                    errors = errors + 1;
                    void'(offset_q.pop_front());
                end else begin
                    void'(offset_q.pop_front());
                end
            end
            if (stall > 0) begin
                stall = stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall = calm ? 0 : pick_gap();
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int              n;
        int              nbuf;
        int              emb;
        int              eff;
        int              r;
        bit              open;
        mbss_pkg::t_byte b;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: a one-byte signature of zero.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        wait_idle(4);

        // Zero length reports every offset.
        write_reg(mbss_pkg::REG_LENGTH, {$urandom, $urandom} & ~64'h1F);
        @(negedge clk);
        add_byte(8'h5A, 1'b0);
        add_byte(8'hA5, 1'b1);
        wait_idle(4);

        // Length above the maximum saturates; one wildcard in the middle.
        write_reg(mbss_pkg::REG_PATTERN_LOW, '1);
        write_reg(mbss_pkg::REG_PATTERN_HIGH, '0);
        write_reg(mbss_pkg::REG_WILDCARD, 64'h0100);
        write_reg(mbss_pkg::REG_LENGTH, 64'd31);
        @(negedge clk);
        for (int j = 0; j < 8; j++)
            add_byte(8'hFF, 1'b0);
        add_byte(mbss_pkg::t_byte'($urandom), 1'b0);
        for (int j = 0; j < 7; j++)
            add_byte(8'h00, j == 6);
        wait_idle(4);

        // The cleared window would match at the buffer start, which must not be reported.
        write_reg(mbss_pkg::REG_PATTERN_LOW, 64'hCD00);
        write_reg(mbss_pkg::REG_WILDCARD, '0);
        write_reg(mbss_pkg::REG_LENGTH, 64'd2);
        @(negedge clk);
        add_byte(8'hCD, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hCD, 1'b1);
        add_byte(8'hCD, 1'b0);
        wait_idle(4);

        while (rand_items < 500) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(mbss_pkg::REG_PATTERN_LOW, rand_pattern());
            if ($urandom_range(0, 3) != 0)
                write_reg(mbss_pkg::REG_PATTERN_HIGH, rand_pattern());
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 5);
                if (r == 0)
                    write_reg(mbss_pkg::REG_WILDCARD, {$urandom, $urandom} & ~64'hFFFF);
                else if (r == 1)
                    write_reg(mbss_pkg::REG_WILDCARD, {$urandom, $urandom} | 64'hFFFF);
                else if (r == 2)
                    write_reg(mbss_pkg::REG_WILDCARD, {$urandom, $urandom});
                else
                    write_reg(mbss_pkg::REG_WILDCARD, 64'($urandom & $urandom));
            end
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    write_reg(mbss_pkg::REG_LENGTH, 64'd0);
                else if (r == 1)
                    write_reg(mbss_pkg::REG_LENGTH, 64'd16);
                else if (r == 2)
                    write_reg(mbss_pkg::REG_LENGTH,
                              {$urandom, 27'd0, 5'($urandom_range(17, 31))});
                else
                    write_reg(mbss_pkg::REG_LENGTH, 64'($urandom_range(1, 15)));
            end
            @(negedge clk);
            nbuf = $urandom_range(1, 4);
            for (int bi = 0; bi < nbuf; bi++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                : $urandom_range(1, 16);
                eff = (sig_len > mbss_pkg::MAX_PATTERN_DEF) ? mbss_pkg::MAX_PATTERN_DEF
                                                             : int'(sig_len);
                emb = eff;
                // Sometimes the phase ends inside a buffer, so the next settings
                // are applied to a window that is still filled.
                open = (bi == nbuf - 1) && ($urandom_range(0, 2) == 0);
                for (int j = 0; j < n; j++) begin
                    if (emb >= eff && $urandom_range(0, 4) == 0)
                        emb = 0;
                    if (emb < eff) begin
                        b = wild_mask[emb] ? mbss_pkg::t_byte'($urandom) : sig_byte(emb);
                        if ($urandom_range(0, 19) == 0)
                            b = mbss_pkg::t_byte'($urandom);
                        emb = emb + 1;
                    end else if ($urandom_range(0, 3) == 0) begin
                        b = sig_byte($urandom_range(0, 15));
                    end else begin
                        b = mbss_pkg::t_byte'($urandom);
                    end
                    add_byte(b, (j == n - 1) && !open);
                end
                rand_items = rand_items + n;
            end
            wait_idle(4);
        end

        wait_idle(10);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
